### hdl/fatlb_pkg.sv
// Shared types and constants for the fully associative TLB.
// Used by fatlb_ctrl, fatlb_dpath and the top level fully_assoc_tlb_lru.
package fatlb_pkg;

	localparam int LINES_DEF       = 128;
	localparam int OFFSET_BITS_DEF = 12;

	localparam int KIND_W   = 2;
	localparam int VPAGE_W  = 36;
	localparam int OFFSET_W = 12;
	localparam int PPAGE_W  = 20;
	localparam int ADDR_W   = 32;
	localparam int LINE_W   = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_FILL   = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_NOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_REDA,
		ST_REDB,
		ST_RES
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic cmp;
		logic reda;
		logic redb;
		logic commit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

### hdl/fatlb_ctrl.sv
// Sequencing state machine for the TLB: accept, compare, reduce, commit.
// Depends on fatlb_pkg for state, command and status types.
module fatlb_ctrl import fatlb_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  kind_t in_kind,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					// only a lookup needs the compare and reduction steps
					state_n = (in_kind == KIND_LOOKUP) ? ST_CMP : ST_RES;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_n = ST_REDA;
			end
			ST_REDA: begin
				cmd.reda = 1'b1;
				state_n  = ST_REDB;
			end
			ST_REDB: begin
				cmd.redb = 1'b1;
				state_n  = ST_RES;
			end
			ST_RES: begin
				// hold until the output register can take the beat
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/fatlb_dpath.sv
// TLB datapath: tag array, parallel compare, registered winner tree,
// frame memory, per-line recency ranks and the output register. Uses fatlb_pkg.
module fatlb_dpath import fatlb_pkg::*; #(
	parameter int LINES       = LINES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VPAGE_W-1:0]  virt_page,
	input  logic [OFFSET_W-1:0] byte_offset,
	input  logic [PPAGE_W-1:0]  phys_page,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                hit,
	output logic [ADDR_W-1:0]   phys_addr,
	output logic [LINE_W-1:0]   line_used
);

	localparam int IW = $clog2(LINES);
	localparam int L  = IW;
	localparam int P  = 1 << L;
	localparam int L1 = L / 2;
	localparam int L2 = L - L1;
	localparam int NA = P >> L1;
	localparam int AW = PPAGE_W + OFFSET_BITS;
	localparam logic [OFFSET_W-1:0] OFF_MASK = OFFSET_W'((64'd1 << OFFSET_BITS) - 64'd1);
	localparam logic [IW-1:0] TOP_RANK = IW'(LINES - 1);

	typedef struct packed {
		logic          m;
		logic [IW-1:0] rank;
		logic [IW-1:0] idx;
	} cand_t;

	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (b.m && (!a.m || (b.rank > a.rank))) begin
			return b;
		end else begin
			return a;
		end
	endfunction

	kind_t                kind_q;
	logic [VPAGE_W-1:0]   vpage_q;
	logic [OFFSET_W-1:0]  off_q;
	logic [PPAGE_W-1:0]   ppage_q;

	logic [VPAGE_W-1:0]   tag_q [LINES];
	logic [LINES-1:0]     valid_q;
	logic [IW-1:0]        rank_q [LINES];
	logic [IW-1:0]        rank_n [LINES];
	logic [IW-1:0]        lru_q;
	logic [IW-1:0]        lru_n;
	logic [IW-1:0]        second_line;

	logic [PPAGE_W-1:0]   frame_mem [LINES];
	logic [PPAGE_W-1:0]   frame_s3;

	logic [LINES-1:0]     match_s1;
	cand_t                ta [L1+1][P];
	cand_t                red_s2 [NA];
	cand_t                tb [L2+1][NA];
	cand_t                cand_win;
	cand_t                win_s3;

	logic                 upd_en;
	logic [IW-1:0]        upd_line;
	logic [IW-1:0]        upd_rank;
	logic [AW-1:0]        full_addr;

	logic                 out_valid_q;
	logic                 hit_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [LINE_W-1:0]    line_q;

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind_t'(kind);
			vpage_q <= virt_page;
			off_q   <= byte_offset;
			ppage_q <= phys_page;
		end
	end

	// parallel tag compare
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			for (int i = 0; i < LINES; i++) begin
				match_s1[i] <= valid_q[i] && (tag_q[i] == vpage_q);
			end
		end
	end

	// first half of the most-recent-match tree
	always_comb begin
		for (int j = 0; j <= L1; j++) begin
			for (int k = 0; k < P; k++) begin
				ta[j][k] = '0;
			end
		end
		for (int k = 0; k < LINES; k++) begin
			ta[0][k].m    = match_s1[k];
			ta[0][k].rank = rank_q[k];
			ta[0][k].idx  = IW'(k);
		end
		for (int j = 0; j < L1; j++) begin
			for (int k = 0; k < (P >> (j + 1)); k++) begin
				ta[j+1][k] = pick(ta[j][2*k], ta[j][2*k+1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reda) begin
			for (int k = 0; k < NA; k++) begin
				red_s2[k] <= ta[L1][k];
			end
		end
	end

	// second half of the tree
	always_comb begin
		for (int j = 0; j <= L2; j++) begin
			for (int k = 0; k < NA; k++) begin
				tb[j][k] = '0;
			end
		end
		for (int k = 0; k < NA; k++) begin
			tb[0][k] = red_s2[k];
		end
		for (int j = 0; j < L2; j++) begin
			for (int k = 0; k < (NA >> (j + 1)); k++) begin
				tb[j+1][k] = pick(tb[j][2*k], tb[j][2*k+1]);
			end
		end
		cand_win = tb[L2][0];
	end

	always_ff @(posedge clk) begin
		if (cmd.redb) begin
			win_s3 <= cand_win;
		end
	end

	// frame memory: fill writes, winner read
	always_ff @(posedge clk) begin
		if (cmd.commit && (kind_q == KIND_FILL)) begin
			frame_mem[lru_q] <= ppage_q;
		end
		if (cmd.redb) begin
			frame_s3 <= frame_mem[cand_win.idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && (kind_q == KIND_FILL)) begin
			tag_q[lru_q] <= vpage_q;
		end
	end

	// recency update: move one line to the top, close the gap above it
	always_comb begin
		upd_en   = 1'b0;
		upd_line = lru_q;
		upd_rank = '0;
		case (kind_q)
			KIND_LOOKUP: begin
				upd_en   = win_s3.m;
				upd_line = win_s3.idx;
				upd_rank = win_s3.rank;
			end
			KIND_FILL: begin
				upd_en = 1'b1;
			end
			default: begin
				upd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		second_line = '0;
		for (int i = 0; i < LINES; i++) begin
			rank_n[i] = rank_q[i];
			if (IW'(i) == upd_line) begin
				rank_n[i] = TOP_RANK;
			end else if (rank_q[i] > upd_rank) begin
				rank_n[i] = rank_q[i] - 1'b1;
			end
			if (rank_q[i] == IW'(1)) begin
				second_line = second_line | IW'(i);
			end
		end
		lru_n = (upd_rank == '0) ? second_line : lru_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			lru_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LINES; i++) begin
				rank_q[i] <= IW'(i);
			end
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (kind_q == KIND_FILL) begin
					valid_q[lru_q] <= 1'b1;
				end
				if (kind_q == KIND_FLUSH) begin
					valid_q <= '0;
				end
				if (upd_en) begin
					rank_q <= rank_n;
					lru_q  <= lru_n;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign full_addr = {frame_s3, {OFFSET_BITS{1'b0}}} | AW'(off_q & OFF_MASK);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q  <= 1'b0;
			addr_q <= '0;
			line_q <= '0;
			case (kind_q)
				KIND_LOOKUP: begin
					if (win_s3.m) begin
						hit_q  <= 1'b1;
						addr_q <= ADDR_W'(full_addr);
						line_q <= LINE_W'(win_s3.idx);
					end
				end
				KIND_FILL: begin
					line_q <= LINE_W'(lru_q);
				end
				default: begin
					line_q <= '0;
				end
			endcase
		end
	end

	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign phys_addr = addr_q;
	assign line_used = line_q;

`ifndef SYNTH
	a_lru_rank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rank_q[lru_q] == '0)
		else $error("replacement pointer does not hold the least recent line");

	a_fill_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (kind_q == KIND_FILL)) |=> valid_q[$past(lru_q)])
		else $error("filled line not marked valid");

	a_winner_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.redb && cand_win.m) |-> match_s1[cand_win.idx])
		else $error("tree winner is not a matching line");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && (kind_q == KIND_FLUSH)) |=> (valid_q == '0))
		else $error("flush left a valid line");
`endif

endmodule

### hdl/fully_assoc_tlb_lru.sv
// Top level of the fully associative TLB with true-LRU replacement.
// Instantiates fatlb_ctrl and fatlb_dpath; types from fatlb_pkg.
//
// Input channel (in_valid/in_ready) carries one request beat: kind selects
// lookup, fill after page walk, flush, or no-op. Output channel
// (out_valid/out_ready) returns one result beat per request: hit,
// phys_addr and line_used.
// A lookup steps through capture, tag compare across all lines,
// two registered steps of the most-recent-match tree (with the frame
// memory read), then commit.
// Fill, flush and no-op go from capture straight to commit.
// Requests are handled one at a time; in_ready is high only while idle.
// When the receiver stalls, the result holds in the output register and the
// next request may still be accepted; its commit waits until that result
// is taken.
// Reset invalidates all lines and sets the recency order to line 0 least
// recent through line LINES-1 most recent; no clearing pass is needed.
module fully_assoc_tlb_lru import fatlb_pkg::*; #(
	parameter int LINES       = LINES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VPAGE_W-1:0]  virt_page,
	input  logic [OFFSET_W-1:0] byte_offset,
	input  logic [PPAGE_W-1:0]  phys_page,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic [ADDR_W-1:0]   phys_addr,
	output logic [LINE_W-1:0]   line_used
);

	cmd_t  cmd;
	stat_t stat;

	fatlb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind_t'(kind)),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fatlb_dpath #(
		.LINES       (LINES),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.virt_page   (virt_page),
		.byte_offset (byte_offset),
		.phys_page   (phys_page),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.hit         (hit),
		.phys_addr   (phys_addr),
		.line_used   (line_used)
	);

endmodule

### tb/sv/fatlb_checker.sv
// Checker for fully_assoc_tlb_lru: watches both channels, predicts translations.
// Keeps its own copy of the tags, frames, valid bits and LRU order.
// Depends on fatlb_pkg for widths and request kinds.
module fatlb_checker import fatlb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VPAGE_W-1:0]  virt_page,
	input  logic [OFFSET_W-1:0] byte_offset,
	input  logic [PPAGE_W-1:0]  phys_page,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                hit,
	input  logic [ADDR_W-1:0]   phys_addr,
	input  logic [LINE_W-1:0]   line_used,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_LINES = LINES_DEF;

	typedef struct {
		logic              hit;
		logic [ADDR_W-1:0] phys_addr;
		logic [LINE_W-1:0] line_used;
	} translation_t;

	logic [VPAGE_W-1:0] tag_mem   [NUM_LINES];
	logic [PPAGE_W-1:0] frame_mem [NUM_LINES];
	logic               valid_mem [NUM_LINES];
	// position 0 is least recent
	logic [LINE_W-1:0]  lru_order [NUM_LINES];

	translation_t awaited_translations[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic void clear_lines();
		for (int i = 0; i < NUM_LINES; i++) begin
			tag_mem[i]   = '0;
			frame_mem[i] = '0;
			valid_mem[i] = 1'b0;
		end
	endfunction

	function automatic void promote(int pos);
		logic [LINE_W-1:0] idx;
		idx = lru_order[pos];
		for (int k = pos; k < NUM_LINES - 1; k++)
			lru_order[k] = lru_order[k + 1];
		lru_order[NUM_LINES - 1] = idx;
	endfunction

	function automatic translation_t translate_and_update(kind_t req_kind,
			logic [VPAGE_W-1:0] vpage, logic [OFFSET_W-1:0] offset,
			logic [PPAGE_W-1:0] ppage);
		translation_t      res;
		logic [LINE_W-1:0] idx;
		res = '{hit: 1'b0, phys_addr: '0, line_used: '0};
		case (req_kind)
			KIND_LOOKUP: begin
				// most recent valid match wins when a page sits in several lines
				for (int p = NUM_LINES - 1; p >= 0; p--) begin
					idx = lru_order[p];
					if (valid_mem[idx] && tag_mem[idx] == vpage) begin
						res.hit       = 1'b1;
						res.phys_addr = {frame_mem[idx], offset};
						res.line_used = idx;
						promote(p);
						break;
					end
				end
			end
			KIND_FILL: begin
				idx            = lru_order[0];
				tag_mem[idx]   = vpage;
				frame_mem[idx] = ppage;
				valid_mem[idx] = 1'b1;
				res.line_used  = idx;
				promote(0);
			end
			KIND_FLUSH: clear_lines();
			default: ;
		endcase
		return res;
	endfunction

	function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
			logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		translation_t want;
		if (!arst_n) begin
			clear_lines();
			for (int i = 0; i < NUM_LINES; i++)
				lru_order[i] = LINE_W'(i);
			awaited_translations.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_translations.size() == 0) begin
					$display("%0t: result beat with nothing awaited, actual hit %0d addr 0x%0h line %0d",
						$time, hit, phys_addr, line_used);
					mismatches++;
				end else begin
					want = awaited_translations.pop_front();
					compare_field("hit", ADDR_W'(want.hit), ADDR_W'(hit));
					compare_field("phys_addr", want.phys_addr, phys_addr);
					compare_field("line_used", ADDR_W'(want.line_used), ADDR_W'(line_used));
				end
			end
			if (in_valid && in_ready)
				awaited_translations.push_back(translate_and_update(kind_t'(kind),
					virt_page, byte_offset, phys_page));
		end
		outstanding = awaited_translations.size();
	end

endmodule

### tb/sv/tb_fully_assoc_tlb_lru.sv
// Testbench top for fully_assoc_tlb_lru: directed and random request beats.
// Instantiates the block and fatlb_checker; types from fatlb_pkg.
module tb_fully_assoc_tlb_lru import fatlb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int PHASE_ITEMS   = 460;
	localparam int POOL_SIZE     = 160;
	localparam int DRAIN_CYCLES  = 10;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic [KIND_W-1:0]   kind        = KIND_NOP;
	logic [VPAGE_W-1:0]  virt_page   = '0;
	logic [OFFSET_W-1:0] byte_offset = '0;
	logic [PPAGE_W-1:0]  phys_page   = '0;
	logic                out_ready   = 1'b0;
	logic                in_ready;
	logic                out_valid;
	logic                hit;
	logic [ADDR_W-1:0]   phys_addr;
	logic [LINE_W-1:0]   line_used;

	int mismatches;
	int outstanding;
	int send_idle_pct = 23;
	int recv_idle_pct = 68;
	int cycle_count   = 0;

	logic [VPAGE_W-1:0] page_pool [POOL_SIZE];

	always #2 clk = ~clk;

	fully_assoc_tlb_lru dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.virt_page  (virt_page),
		.byte_offset(byte_offset),
		.phys_page  (phys_page),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.phys_addr  (phys_addr),
		.line_used  (line_used)
	);

	fatlb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.virt_page  (virt_page),
		.byte_offset(byte_offset),
		.phys_page  (phys_page),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.phys_addr  (phys_addr),
		.line_used  (line_used),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_fully_assoc_tlb_lru failed");
			$finish;
		end
	end

	// Present one request beat and hold it until accepted.
	task automatic send_request(kind_t k, logic [VPAGE_W-1:0] vp,
			logic [OFFSET_W-1:0] off, logic [PPAGE_W-1:0] pp);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		virt_page   <= vp;
		byte_offset <= off;
		phys_page   <= pp;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_random_request();
		int                 r;
		logic [VPAGE_W-1:0] vp;
		kind_t              k;
		r  = $urandom_range(999);
		vp = page_pool[$urandom_range(POOL_SIZE - 1)];
		if (r < 520)
			k = KIND_LOOKUP;
		else if (r < 600) begin
			k  = KIND_LOOKUP;
			vp = {4'($urandom), 32'($urandom)};
		end else if (r < 960)
			k = KIND_FILL;
		else if (r < 963)
			k = KIND_FLUSH;
		else
			k = KIND_NOP;
		send_request(k, vp, 12'($urandom), 20'($urandom));
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			page_pool[i] = {4'($urandom), 32'($urandom)};
		page_pool[0] = '0;
		page_pool[1] = '1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, fill order, extremes, duplicate pages, flush keeps LRU order
		send_request(KIND_LOOKUP, '0, '0, '0);
		send_request(KIND_NOP, '1, '1, '1);
		send_request(KIND_FILL, '0, '0, '0);
		send_request(KIND_LOOKUP, '0, '1, '0);
		send_request(KIND_FILL, '1, '0, '1);
		send_request(KIND_LOOKUP, '1, '0, '0);
		send_request(KIND_LOOKUP, '1, '1, '0);
		send_request(KIND_FILL, 36'h123456789, 12'h000, 20'hABCDE);
		send_request(KIND_FILL, 36'h123456789, 12'h000, 20'h13579);
		send_request(KIND_LOOKUP, 36'h123456789, 12'h5A5, '0);
		send_request(KIND_LOOKUP, 36'h123456788, 12'h5A5, '0);
		send_request(KIND_LOOKUP, '0, 12'h800, '0);
		send_request(KIND_FLUSH, 36'h123456789, '1, '1);
		send_request(KIND_LOOKUP, '0, '0, '0);
		send_request(KIND_LOOKUP, '1, '1, '0);
		send_request(KIND_FILL, 36'h000000005, '0, 20'h00005);
		send_request(KIND_LOOKUP, 36'h000000005, 12'hA5A, '0);
		send_request(KIND_LOOKUP, 36'h800000000, '1, '1);
		send_request(KIND_NOP, '0, '0, '0);
		send_request(KIND_LOOKUP, 36'h123456789, '0, '0);

		for (int n = 0; n < PHASE_ITEMS; n++)
			send_random_request();
		send_idle_pct = 68;
		recv_idle_pct = 23;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_random_request();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int n = 0; n < PHASE_ITEMS; n++)
			send_random_request();
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb_fully_assoc_tlb_lru passed");
		else
			$display("tb_fully_assoc_tlb_lru failed");
		$finish;
	end

endmodule

### sim.f
hdl/fatlb_pkg.sv
hdl/fatlb_ctrl.sv
hdl/fatlb_dpath.sv
hdl/fully_assoc_tlb_lru.sv
tb/sv/fatlb_checker.sv
tb/sv/tb_fully_assoc_tlb_lru.sv
